/* hdl/iiss_pkg.sv */
// ----------------------------------------------------------------------------
// iiss_pkg
// Shared types, character codes and result-slot codes for the inline image
// sample stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package iiss_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // result slots of one command, emitted lowest first
  localparam int unsigned NUM_SLOTS = 11;
  localparam int unsigned SLOT_W    = 4;

  localparam logic [SLOT_W-1:0] SLOT_I        = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_D        = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRE_SP   = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_PRE_E    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_PRE_I    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_PRE_REC  = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_BYTE     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_POST_SP  = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_POST_E   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_POST_I   = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_POST_REC = 4'd10;

  // command queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // one classified input byte: which results it causes
  typedef struct packed {
    slot_mask_t  mask;
    logic [7:0]  data;
    logic [31:0] rng_begin;
    logic [31:0] rng_end;
  } cmd_t;

  // front to queue
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_wr_t;

  // queue to back
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_rd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_SP);
  endfunction

  function automatic logic is_stop_char(input logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC) || (c == CH_RBRC) ||
           (c == CH_SLASH) || (c == CH_PCT);
  endfunction

endpackage

`default_nettype wire

/* hdl/iiss_if.sv */
// ----------------------------------------------------------------------------
// iiss_if
// Valid/ready channels of the stripper: raw byte input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface iiss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface iiss_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [31:0] range_begin;
  logic [31:0] range_finish;
  logic        run_end;

  modport source (output valid, output out_kind, output out_byte, output range_begin,
                  output range_finish, output run_end, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input range_begin,
                  input range_finish, input run_end, output ready);
endinterface

`default_nettype wire

/* hdl/iiss_front.sv */
// ----------------------------------------------------------------------------
// iiss_front
// Lexical tracker: takes one byte per transfer, updates the lexing mode and
// turns the byte into a command listing the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module iiss_front
  import iiss_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned DEPTH_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  iiss_in_if.sink     in_if,
  input  wire logic   q_full,
  output q_wr_t       q_wr
);

  typedef enum logic [2:0] {
    M_NORMAL,
    M_COMMENT,
    M_STRING,
    M_HEX,
    M_SAMPLE,
    M_SAMPLE_E,
    M_SAMPLE_EI
  } mode_t;

  typedef logic [OFFSET_BITS-1:0] off_t;

  function automatic logic in_sample(input mode_t m);
    return (m == M_SAMPLE) || (m == M_SAMPLE_E) || (m == M_SAMPLE_EI);
  endfunction

  mode_t                 mode_r, mode_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic                  esc_r, esc_nxt;
  logic                  dict_r, dict_nxt;
  logic [7:0]            prev_r;
  logic [7:0]            pp_r;
  logic                  start_r;
  logic [1:0]            held_r, held_nxt;
  off_t                  pos_r;
  off_t                  sb_r, sb_nxt;

  logic                  acc;
  logic [7:0]            b;
  logic                  last;

  // plain-mode byte handling
  mode_t                 nb_mode_in, nb_mode;
  logic [DEPTH_BITS-1:0] nb_depth;
  logic                  nb_esc, nb_dict, nb_put, nb_hold, nb_skip;

  // command build
  slot_mask_t            mask;
  logic                  use_nb, fin_pre, fin_post, fin_trim_ok;
  off_t                  fin_raw, fin_trim, fin_end;
  logic [OFFSET_BITS+31:0] wide_begin, wide_end;

  assign b    = in_if.in_byte;
  assign last = in_if.in_last;
  assign in_if.ready = !q_full;
  assign acc  = in_if.valid && !q_full;

  // sample modes fall back to normal before the byte is lexed again
  assign nb_mode_in = in_sample(mode_r) ? M_NORMAL : mode_r;

  // lexing of one byte outside a sample run
  always_comb begin
    nb_mode  = nb_mode_in;
    nb_depth = depth_r;
    nb_esc   = esc_r;
    nb_dict  = dict_r;
    nb_put   = 1'b0;
    nb_hold  = 1'b0;
    nb_skip  = 1'b0;
    if (dict_r) begin
      nb_dict = 1'b0;
      if (b == CH_LT) begin
        nb_put  = 1'b1;
        nb_skip = 1'b1;
      end else begin
        nb_mode = M_HEX;
      end
    end
    if (!nb_skip) begin
      unique case (nb_mode)
        M_COMMENT: begin
          nb_put = 1'b1;
          if (b == CH_LF || b == CH_CR) nb_mode = M_NORMAL;
        end
        M_STRING: begin
          nb_put = 1'b1;
          if (esc_r) begin
            nb_esc = 1'b0;
          end else if (b == CH_BSL) begin
            nb_esc = 1'b1;
          end else if (b == CH_LPAR) begin
            if (depth_r != '1) nb_depth = depth_r + 1'b1;
          end else if (b == CH_RPAR) begin
            if (depth_r != '0) nb_depth = depth_r - 1'b1;
            if (nb_depth == '0) nb_mode = M_NORMAL;
          end
        end
        M_HEX: begin
          nb_put = 1'b1;
          if (b == CH_GT) nb_mode = M_NORMAL;
        end
        default: begin
          if (b == CH_PCT) begin
            nb_mode = M_COMMENT;
            nb_put  = 1'b1;
          end else if (b == CH_LPAR) begin
            nb_mode  = M_STRING;
            nb_depth = DEPTH_BITS'(1);
            nb_put   = 1'b1;
          end else if (b == CH_LT) begin
            nb_dict = 1'b1;
            nb_put  = 1'b1;
          end else if (b == CH_I && !last &&
                       (start_r || is_ws(prev_r) || prev_r == CH_GT)) begin
            nb_hold = 1'b1;
          end else begin
            nb_put = 1'b1;
          end
        end
      endcase
    end
  end

  // classify the byte and pick its results
  always_comb begin
    mode_nxt    = mode_r;
    depth_nxt   = depth_r;
    esc_nxt     = esc_r;
    dict_nxt    = dict_r;
    held_nxt    = held_r;
    sb_nxt      = sb_r;
    mask        = '0;
    use_nb      = 1'b0;
    fin_pre     = 1'b0;
    fin_post    = 1'b0;
    fin_raw     = pos_r;
    fin_trim_ok = 1'b0;

    if (in_sample(mode_r)) begin
      if (mode_r == M_SAMPLE_EI) begin
        if (is_ws(b) || is_stop_char(b)) begin
          fin_pre     = 1'b1;
          fin_raw     = pos_r - off_t'(2);
          fin_trim_ok = 1'b1;
          use_nb      = 1'b1;
        end else begin
          mode_nxt = M_SAMPLE;
        end
      end else if (mode_r == M_SAMPLE_E) begin
        if (b == CH_I) begin
          if (last) begin
            fin_pre     = 1'b1;
            fin_raw     = pos_r - off_t'(1);
            fin_trim_ok = 1'b1;
            mode_nxt    = M_NORMAL;
          end else begin
            mode_nxt = M_SAMPLE_EI;
          end
        end else begin
          mode_nxt = M_SAMPLE;
        end
      end else if (b == CH_E && is_ws(prev_r)) begin
        mode_nxt = M_SAMPLE_E;
      end
    end else if (held_r == 2'd1) begin
      if (b == CH_D) begin
        if (last) begin
          mask[SLOT_I] = 1'b1;
          mask[SLOT_D] = 1'b1;
          sb_nxt       = pos_r + off_t'(1);
          fin_pre      = 1'b1;
          fin_raw      = pos_r + off_t'(1);
          held_nxt     = 2'd0;
          mode_nxt     = M_NORMAL;
        end else begin
          held_nxt = 2'd2;
        end
      end else begin
        mask[SLOT_I] = 1'b1;
        held_nxt     = 2'd0;
        use_nb       = 1'b1;
      end
    end else if (held_r == 2'd2) begin
      mask[SLOT_I] = 1'b1;
      mask[SLOT_D] = 1'b1;
      held_nxt     = 2'd0;
      if (is_ws(b)) begin
        mode_nxt = M_SAMPLE;
        sb_nxt   = pos_r + off_t'(1);
      end else begin
        use_nb = 1'b1;
      end
    end else begin
      use_nb = 1'b1;
    end

    if (use_nb) begin
      mode_nxt        = nb_mode;
      depth_nxt       = nb_depth;
      esc_nxt         = nb_esc;
      dict_nxt        = nb_dict;
      mask[SLOT_BYTE] = nb_put;
      if (nb_hold) held_nxt = 2'd1;
    end

    // run still open at the end of the stream
    if (last && in_sample(mode_nxt)) begin
      fin_post    = 1'b1;
      fin_raw     = pos_r - off_t'(1);
      fin_trim_ok = is_ws(pp_r);
      mode_nxt    = M_NORMAL;
    end

    if (fin_pre) begin
      mask[SLOT_PRE_SP]  = 1'b1;
      mask[SLOT_PRE_E]   = 1'b1;
      mask[SLOT_PRE_I]   = 1'b1;
      mask[SLOT_PRE_REC] = 1'b1;
    end
    if (fin_post) begin
      mask[SLOT_POST_SP]  = 1'b1;
      mask[SLOT_POST_E]   = 1'b1;
      mask[SLOT_POST_I]   = 1'b1;
      mask[SLOT_POST_REC] = 1'b1;
    end
  end

  // run end: trim one whitespace, never before the run start
  always_comb begin
    fin_trim = (fin_trim_ok && fin_raw > sb_nxt) ? fin_raw - off_t'(1) : fin_raw;
    fin_end  = (fin_trim < sb_nxt) ? sb_nxt : fin_trim;
  end

  // offsets are reported in 32 bits
  assign wide_begin = {32'd0, sb_nxt};
  assign wide_end   = {32'd0, fin_end};

  assign q_wr.vld           = acc && (mask != '0);
  assign q_wr.cmd.mask      = mask;
  assign q_wr.cmd.data      = b;
  assign q_wr.cmd.rng_begin = wide_begin[31:0];
  assign q_wr.cmd.rng_end   = wide_end[31:0];

  // lexer state, back to the start of a stream after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      depth_r <= '0;
      esc_r   <= 1'b0;
      dict_r  <= 1'b0;
      prev_r  <= '0;
      pp_r    <= '0;
      start_r <= 1'b1;
      held_r  <= 2'd0;
      pos_r   <= '0;
      sb_r    <= '0;
    end else if (acc) begin
      if (last) begin
        mode_r  <= M_NORMAL;
        depth_r <= '0;
        esc_r   <= 1'b0;
        dict_r  <= 1'b0;
        prev_r  <= '0;
        pp_r    <= '0;
        start_r <= 1'b1;
        held_r  <= 2'd0;
        pos_r   <= '0;
        sb_r    <= '0;
      end else begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        esc_r   <= esc_nxt;
        dict_r  <= dict_nxt;
        prev_r  <= b;
        pp_r    <= prev_r;
        start_r <= 1'b0;
        held_r  <= held_nxt;
        pos_r   <= pos_r + off_t'(1);
        sb_r    <= sb_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/iiss_queue.sv */
// ----------------------------------------------------------------------------
// iiss_queue
// Small command FIFO between the lexer front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iiss_queue
  import iiss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  output q_rd_t      q_rd,
  input  wire logic  q_pop
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            push;
  logic            pop;

  assign q_full   = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign push     = q_wr.vld && !q_full;
  assign pop      = q_pop && (cnt_r != '0);
  assign q_rd.vld = (cnt_r != '0);
  assign q_rd.cmd = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= q_wr.cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/iiss_back.sv */
// ----------------------------------------------------------------------------
// iiss_back
// Result sequencer: walks the slots of the head command, one result per
// transfer, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iiss_back
  import iiss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_rd_t  q_rd,
  output logic        q_pop,
  iiss_out_if.source  out_if
);

  slot_mask_t        done_r;
  slot_mask_t        rem;
  slot_mask_t        low;
  logic [SLOT_W-1:0] idx;
  logic              is_last;
  logic              load;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [7:0]        out_byte_r;
  logic [31:0]       rb_r;
  logic [31:0]       rf_r;
  logic              run_end_r;

  logic              s_kind;
  logic [7:0]        s_byte;

  // next slot still owed by the head command
  assign rem     = q_rd.cmd.mask & ~done_r;
  assign low     = rem & (~rem + 1'b1);
  assign is_last = ((rem & ~low) == '0);
  assign load    = !out_valid_r || out_if.ready;
  assign q_pop   = load && q_rd.vld && is_last;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low[i]) idx = SLOT_W'(i);
    end
  end

  // slot decode
  always_comb begin
    s_kind = 1'b0;
    s_byte = '0;
    unique case (idx) inside
      SLOT_I, SLOT_PRE_I, SLOT_POST_I: s_byte = CH_I;
      SLOT_D:                          s_byte = CH_D;
      SLOT_PRE_SP, SLOT_POST_SP:       s_byte = CH_SP;
      SLOT_PRE_E, SLOT_POST_E:         s_byte = CH_E;
      SLOT_PRE_REC, SLOT_POST_REC:     s_kind = 1'b1;
      SLOT_BYTE:                       s_byte = q_rd.cmd.data;
      default:                         s_byte = '0;
    endcase
  end

  // output register and slot progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else if (load) begin
      out_valid_r <= q_rd.vld;
      if (q_rd.vld) begin
        done_r <= is_last ? '0 : (done_r | low);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_rd.vld) begin
      out_kind_r <= s_kind;
      out_byte_r <= s_byte;
      rb_r       <= s_kind ? q_rd.cmd.rng_begin : '0;
      rf_r       <= s_kind ? q_rd.cmd.rng_end : '0;
      run_end_r  <= is_last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_kind     = out_kind_r;
  assign out_if.out_byte     = out_byte_r;
  assign out_if.range_begin  = rb_r;
  assign out_if.range_finish = rf_r;
  assign out_if.run_end      = run_end_r;

endmodule

`default_nettype wire

/* hdl/inline_image_sample_stripper.sv */
// ----------------------------------------------------------------------------
// inline_image_sample_stripper
// Copies a content stream byte for byte, cuts inline image samples out and
// reports each cut range.
// ----------------------------------------------------------------------------
// One byte is taken per clock whenever the four-entry command queue has room;
// the lexer classifies it combinationally in that cycle. Each byte yields zero
// to six results; the result sequencer delivers one result per clock, while the
// output is ready, from the queue head through a registered output, so plain
// bytes flow at one per cycle unless the output stalls. A result passes through
// its queue entry and then the output register. Bytes that end an inline image
// (up to six results) hold the output for one transfer per result; the queue
// absorbs such bursts. run_end flags the last result caused by a byte. After a
// byte with in_last the block restarts at offset zero.
`default_nettype none

module inline_image_sample_stripper
  import iiss_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned DEPTH_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  iiss_in_if.sink     in_if,
  iiss_out_if.source  out_if
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  iiss_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  iiss_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  iiss_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

  // the front never writes a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.vld |-> !q_full)
    else $error("command written into full queue");

  // the back only retires a command that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.vld)
    else $error("command retired from empty queue");

  // a waiting command reaches a free output stage in the next cycle
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_rd.vld && (!out_if.valid || out_if.ready)) |=> out_if.valid)
    else $error("output stage left empty while a command waits");

endmodule

`default_nettype wire
